// ===== rtl/core/nnact_pkg.sv =====
// shared types, constants and the exp table for the activation unit
`timescale 1ns / 1ps
package nnact_pkg;

    localparam int LANES             = 4;
    localparam int FRAC_BITS         = 12;
    localparam int EXP_TABLE_ENTRIES = 64;
    localparam int EXP_IDX_BITS      = $clog2(EXP_TABLE_ENTRIES);
    localparam int DATA_W            = 16;
    localparam int EXP_W             = 17;
    localparam int EXP_FRAC_W        = FRAC_BITS + 16;
    localparam int Q_BITS            = FRAC_BITS + 1;
    localparam int NUM_W             = FRAC_BITS + 17;

    // lane stages 0..LANE_STAGES-1, divider takes the last Q_BITS of them
    localparam int LANE_STAGES       = 18;
    localparam int DIV_FIRST         = LANE_STAGES - Q_BITS;

    localparam logic [16:0]        LOG2E_Q16      = 17'd94548;
    localparam longint unsigned    LN2_Q32        = 64'd2977044472;
    localparam logic signed [17:0] SLOPE_Q16      = 18'sd6554;
    localparam logic signed [17:0] ELU_ALPHA_Q16  = 18'sd6554;
    localparam logic signed [17:0] SELU_ALPHA_Q16 = 18'sd109661;
    localparam logic signed [17:0] SELU_SCALE_Q16 = 18'sd68859;
    localparam logic [EXP_W-1:0]   EXP_ONE        = EXP_W'(65536);
    localparam logic [Q_BITS-1:0]  ONE_Q          = Q_BITS'(1 << FRAC_BITS);

    localparam logic signed [DATA_W-1:0] OUT_MAX = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] OUT_MIN = 16'sh8000;

    // configuration register indexes
    localparam logic REG_KIND = 1'b0;

    typedef enum logic [2:0] {
        ACT_RELU    = 3'd0,
        ACT_LEAKY   = 3'd1,
        ACT_ELU     = 3'd2,
        ACT_SELU    = 3'd3,
        ACT_TANH    = 3'd4,
        ACT_SIGMOID = 3'd5
    } act_kind_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] in_lane0;
        logic signed [DATA_W-1:0] in_lane1;
        logic signed [DATA_W-1:0] in_lane2;
        logic signed [DATA_W-1:0] in_lane3;
        logic                     group_end;
    } act_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_lane0;
        logic signed [DATA_W-1:0] out_lane1;
        logic signed [DATA_W-1:0] out_lane2;
        logic signed [DATA_W-1:0] out_lane3;
        logic                     group_end_out;
        logic                     clipped;
    } res_word_t;

    typedef logic [EXP_W-1:0] exp_tab_t [0:EXP_TABLE_ENTRIES];

    // 2^(-k/entries) in Q16 from an integer taylor series of exp(-x)
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t        t;
        longint unsigned x;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned ngs;
        for (int k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
            x    = (64'(k) * LN2_Q32 + 64'(EXP_TABLE_ENTRIES / 2)) / 64'(EXP_TABLE_ENTRIES);
            term = 64'h1_0000_0000;
            pos  = 64'h1_0000_0000;
            ngs  = 64'd0;
            for (int n = 1; n <= 20; n++) begin
                term = ((term * x) >> 32) / 64'(n);
                if ((n % 2) == 1)
                begin
                    ngs = ngs + term;
                end
                else
                begin
                    pos = pos + term;
                end
            end
            t[k] = EXP_W'(((pos - ngs) + 64'd32768) >> 16);
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== rtl/core/nnact_div.sv =====
// pipelined restoring divider, one quotient bit per stage: (2^28 + d/2) / d
`timescale 1ns / 1ps
module nnact_div (
    input  logic                        clk,
    input  logic [nnact_pkg::Q_BITS-1:0] ld,
    input  logic [17:0]                 d_in,
    output logic [nnact_pkg::Q_BITS-1:0] q
);
    import nnact_pkg::*;

    logic [NUM_W-1:0]  num;
    logic [17:0]       rem_reg  [0:Q_BITS-1];
    logic [17:0]       d_reg    [0:Q_BITS-1];
    logic [Q_BITS-1:0] nl_reg   [0:Q_BITS-1];
    logic [Q_BITS-1:0] q_reg    [0:Q_BITS-1];
    logic [17:0]       rem_next [0:Q_BITS-1];
    logic [Q_BITS-1:0] q_next   [0:Q_BITS-1];

    assign num = (NUM_W'(1) << (NUM_W - 1)) + NUM_W'(d_in >> 1);

    genvar j;
    generate
        for (j = 0; j < Q_BITS; j++) begin : g_step
            logic [17:0]       prem;
            logic [17:0]       pd;
            logic [Q_BITS-1:0] pnl;
            logic [Q_BITS-1:0] pq;
            logic [17:0]       trial;

            if (j == 0) begin : g_first
                assign prem = 18'(num[NUM_W-1:Q_BITS]);
                assign pd   = d_in;
                assign pnl  = num[Q_BITS-1:0];
                assign pq   = '0;
            end
            else begin : g_next
                assign prem = rem_reg[j-1];
                assign pd   = d_reg[j-1];
                assign pnl  = nl_reg[j-1];
                assign pq   = q_reg[j-1];
            end

            assign trial = {prem[16:0], pnl[Q_BITS-1-j]};

            always_comb
            begin
                if (trial >= pd)
                begin
                    rem_next[j] = trial - pd;
                    q_next[j]   = pq | (Q_BITS'(1) << (Q_BITS - 1 - j));
                end
                else
                begin
                    rem_next[j] = trial;
                    q_next[j]   = pq;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ld[j])
                begin
                    rem_reg[j] <= rem_next[j];
                    d_reg[j]   <= pd;
                    nl_reg[j]  <= pnl;
                    q_reg[j]   <= q_next[j];
                end
            end
        end
    endgenerate

    assign q = q_reg[Q_BITS-1];

endmodule

// ===== rtl/core/nnact_lane.sv =====
// one activation lane: exp by power of two and table, aux multiplies, sigmoid divide
`timescale 1ns / 1ps
module nnact_lane (
    input  logic                             clk,
    input  logic [nnact_pkg::LANE_STAGES-1:0] ld,
    input  logic signed [15:0]               x_in,
    input  nnact_pkg::act_kind_t             kind_in,
    output logic signed [15:0]               y,
    output logic                             clip
);
    import nnact_pkg::*;

    typedef struct packed {
        logic signed [17:0] aux;
        logic               neg;
        act_kind_t          kind;
    } aux_t;

    // stage 0
    logic signed [15:0] x0_reg;
    act_kind_t          k0_reg;
    logic signed [16:0] eff;
    logic               neg0;
    logic [16:0]        mag;

    // stages 1..4
    logic [33:0]              y1_reg;
    logic signed [15:0]       x1_reg, x2_reg, x3_reg, x4_reg;
    act_kind_t                k1_reg, k2_reg, k3_reg, k4_reg;
    logic                     n1_reg, n2_reg, n3_reg, n4_reg;
    logic [EXP_IDX_BITS-1:0]  idx;
    logic [EXP_IDX_BITS:0]    idx1;
    logic [5:0]               sh2_reg, sh3_reg;
    logic [EXP_FRAC_W-1:0]    r2_reg;
    logic [EXP_W-1:0]         a2_reg, a3_reg, diff2_reg;
    logic [EXP_W+EXP_FRAC_W-1:0] prod3_reg;
    logic [EXP_W-1:0]         v;
    logic [EXP_W:0]           vsh;
    logic [EXP_W-1:0]         e4_reg;

    // aux path
    logic signed [17:0] opa, opb;
    logic signed [35:0] p5_reg, p7_reg;
    logic signed [15:0] x5_reg;
    act_kind_t          k5_reg, k6_reg, k7_reg;
    logic               n5_reg, n6_reg, n7_reg;
    logic signed [17:0] t6_next, t6_reg, t7_reg;
    aux_t               a8_next;
    aux_t               ad_reg [DIV_FIRST+3:LANE_STAGES-1];

    // final
    logic [Q_BITS-1:0]  q;
    logic [Q_BITS-1:0]  s;
    logic signed [18:0] res;
    aux_t               fin;

    always_comb
    begin
        if (k0_reg == ACT_TANH)
        begin
            eff = {x0_reg, 1'b0};
        end
        else
        begin
            eff = {x0_reg[15], x0_reg};
        end
        neg0 = eff[16];
        mag  = neg0 ? (~eff + 17'd1) : eff;
    end

    assign idx  = y1_reg[EXP_FRAC_W-1 -: EXP_IDX_BITS];
    assign idx1 = {1'b0, idx} + (EXP_IDX_BITS + 1)'(1);

    // interpolate, then rounding shift by the integer part of the exponent
    assign v   = a3_reg - EXP_W'((prod3_reg + (EXP_W + EXP_FRAC_W)'(1 << (EXP_FRAC_W - 1)))
                                 >> EXP_FRAC_W);
    assign vsh = ({v, 1'b0} >> sh3_reg) + (EXP_W + 1)'(1);

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            x0_reg <= x_in;
            k0_reg <= kind_in;
        end
        if (ld[1])
        begin
            y1_reg <= 34'(mag) * 34'(LOG2E_Q16);
            x1_reg <= x0_reg;
            k1_reg <= k0_reg;
            n1_reg <= neg0;
        end
        if (ld[2])
        begin
            sh2_reg   <= y1_reg[33:EXP_FRAC_W];
            r2_reg    <= EXP_FRAC_W'(y1_reg[EXP_FRAC_W-EXP_IDX_BITS-1:0]) << EXP_IDX_BITS;
            a2_reg    <= EXP_TAB[idx];
            diff2_reg <= EXP_TAB[idx] - EXP_TAB[idx1];
            x2_reg    <= x1_reg;
            k2_reg    <= k1_reg;
            n2_reg    <= n1_reg;
        end
        if (ld[3])
        begin
            prod3_reg <= (EXP_W + EXP_FRAC_W)'(diff2_reg) * (EXP_W + EXP_FRAC_W)'(r2_reg);
            a3_reg    <= a2_reg;
            sh3_reg   <= sh2_reg;
            x3_reg    <= x2_reg;
            k3_reg    <= k2_reg;
            n3_reg    <= n2_reg;
        end
        if (ld[4])
        begin
            e4_reg <= EXP_W'(vsh >> 1);
            x4_reg <= x3_reg;
            k4_reg <= k3_reg;
            n4_reg <= n3_reg;
        end
    end

    nnact_div u_div (
        .clk  (clk),
        .ld   (ld[LANE_STAGES-1:DIV_FIRST]),
        .d_in (18'(EXP_ONE) + 18'(e4_reg)),
        .q    (q)
    );

    // shared first multiply: slope, elu alpha or selu alpha
    always_comb
    begin
        case (k4_reg)
            ACT_ELU:
            begin
                opa = $signed({1'b0, e4_reg}) - 18'sd65536;
                opb = ELU_ALPHA_Q16;
            end
            ACT_SELU:
            begin
                opa = $signed({1'b0, e4_reg}) - 18'sd65536;
                opb = SELU_ALPHA_Q16;
            end
            default:
            begin
                opa = 18'(x4_reg);
                opb = SLOPE_Q16;
            end
        endcase
    end

    always_comb
    begin
        case (k5_reg)
            ACT_RELU:  t6_next = n5_reg ? 18'sd0 : 18'(x5_reg);
            ACT_LEAKY: t6_next = n5_reg ? 18'((p5_reg + 36'sd32768) >>> 16) : 18'(x5_reg);
            ACT_ELU,
            ACT_SELU:  t6_next = n5_reg ? 18'((p5_reg + 36'sd524288) >>> 20) : 18'(x5_reg);
            default:   t6_next = 18'(x5_reg);
        endcase
    end

    always_comb
    begin
        a8_next.neg  = n7_reg;
        a8_next.kind = k7_reg;
        if (k7_reg == ACT_SELU)
        begin
            a8_next.aux = 18'((p7_reg + 36'sd32768) >>> 16);
        end
        else
        begin
            a8_next.aux = t7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[DIV_FIRST])
        begin
            p5_reg <= opa * opb;
            x5_reg <= x4_reg;
            k5_reg <= k4_reg;
            n5_reg <= n4_reg;
        end
        if (ld[DIV_FIRST+1])
        begin
            t6_reg <= t6_next;
            k6_reg <= k5_reg;
            n6_reg <= n5_reg;
        end
        if (ld[DIV_FIRST+2])
        begin
            p7_reg <= t6_reg * SELU_SCALE_Q16;
            t7_reg <= t6_reg;
            k7_reg <= k6_reg;
            n7_reg <= n6_reg;
        end
    end

    // aux result waits alongside the divider
    genvar g;
    generate
        for (g = DIV_FIRST + 3; g < LANE_STAGES; g++) begin : g_dly
            always_ff @(posedge clk)
            begin
                if (ld[g])
                begin
                    if (g == DIV_FIRST + 3)
                    begin
                        ad_reg[g] <= a8_next;
                    end
                    else
                    begin
                        ad_reg[g] <= ad_reg[(g == DIV_FIRST + 3) ? g : g - 1];
                    end
                end
            end
        end
    endgenerate

    assign fin = ad_reg[LANE_STAGES-1];
    assign s   = fin.neg ? (ONE_Q - q) : q;

    always_comb
    begin
        case (fin.kind)
            ACT_TANH:    res = 19'(s) + 19'(s) - 19'(ONE_Q);
            ACT_SIGMOID: res = 19'(s);
            default:     res = 19'(fin.aux);
        endcase
        clip = 1'b0;
        y    = res[15:0];
        if (res > 19'(OUT_MAX))
        begin
            y    = OUT_MAX;
            clip = 1'b1;
        end
        else if (res < 19'(OUT_MIN))
        begin
            y    = OUT_MIN;
            clip = 1'b1;
        end
    end

endmodule

// ===== rtl/core/nn_activation_unit_core.sv =====
// top level: config register, lane array, valid pipeline and output merge
`timescale 1ns / 1ps
// Four-lane activation unit. One word of four Q4.12 activations is taken every
// cycle and throughput is one word per cycle with no gaps, as long as res_ready
// does not stall the output. The pipeline depth is set by the per-lane sigmoid
// divider, which resolves one quotient bit per stage over 13 stages, after five
// stages of exponent work (input register, log2(e) multiply, table lookup,
// interpolation, shift), plus the output register. All functions share the
// same pipeline, so latency does not depend on the kind.
// The activation kind register sits at byte address 0 and should only be
// changed while the pipeline is empty. clipped is high when any lane saturated.
module nn_activation_unit_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  act_valid,
    output logic                  act_ready,
    input  nnact_pkg::act_word_t  act,
    output logic                  res_valid,
    input  logic                  res_ready,
    output nnact_pkg::res_word_t  res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import nnact_pkg::*;

    localparam int OUT_STAGE = LANE_STAGES;

    act_kind_t               kind_reg;
    logic [OUT_STAGE:0]      v_reg;
    logic [OUT_STAGE:0]      v_next;
    logic [OUT_STAGE:0]      src;
    logic [OUT_STAGE:0]      rdy;
    logic [OUT_STAGE:0]      load;
    logic [LANE_STAGES-1:0]  ge_reg;
    logic signed [15:0]      lane_x [0:LANES-1];
    logic signed [15:0]      lane_y [0:LANES-1];
    logic [LANES-1:0]        lane_clip;
    res_word_t               res_reg;
    res_word_t               res_next;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_KIND) ? {29'd0, kind_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= ACT_RELU;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_KIND))
        begin
            kind_reg <= act_kind_t'(pwdata[2:0]);
        end
    end

    // valid pipeline, a stage moves when the next one is free or moving
    always_comb
    begin
        src[0] = act_valid;
        for (int k = 1; k <= OUT_STAGE; k++) begin
            src[k] = v_reg[k-1];
        end
        rdy[OUT_STAGE] = !v_reg[OUT_STAGE] || res_ready;
        for (int k = OUT_STAGE - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        for (int k = 0; k <= OUT_STAGE; k++) begin
            load[k]   = src[k] && rdy[k];
            v_next[k] = rdy[k] ? src[k] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign act_ready = rdy[0];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LANE_STAGES; k++) begin
            if (load[k])
            begin
                ge_reg[k] <= (k == 0) ? act.group_end : ge_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign lane_x[0] = act.in_lane0;
    assign lane_x[1] = act.in_lane1;
    assign lane_x[2] = act.in_lane2;
    assign lane_x[3] = act.in_lane3;

    genvar l;
    generate
        for (l = 0; l < LANES; l++) begin : g_lane
            nnact_lane u_lane (
                .clk     (clk),
                .ld      (load[LANE_STAGES-1:0]),
                .x_in    (lane_x[l]),
                .kind_in (kind_reg),
                .y       (lane_y[l]),
                .clip    (lane_clip[l])
            );
        end
    endgenerate

    // merge lanes into the output word
    always_comb
    begin
        res_next.out_lane0     = lane_y[0];
        res_next.out_lane1     = lane_y[1];
        res_next.out_lane2     = lane_y[2];
        res_next.out_lane3     = lane_y[3];
        res_next.group_end_out = ge_reg[LANE_STAGES-1];
        res_next.clipped       = |lane_clip;
    end

    always_ff @(posedge clk)
    begin
        if (load[OUT_STAGE])
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = v_reg[OUT_STAGE];
    assign res       = res_reg;

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.clipped |->
            (res.out_lane0 == OUT_MAX) || (res.out_lane0 == OUT_MIN) ||
            (res.out_lane1 == OUT_MAX) || (res.out_lane1 == OUT_MIN) ||
            (res.out_lane2 == OUT_MAX) || (res.out_lane2 == OUT_MIN) ||
            (res.out_lane3 == OUT_MAX) || (res.out_lane3 == OUT_MIN))
        else $error("clipped word without a saturated lane");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[OUT_STAGE] |-> act_ready)
        else $error("input stalled while output stage empty");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        load[0] |=> v_reg[0])
        else $error("accepted word lost at first stage");

endmodule
